[design/tcw_pkg.sv]
// Shared constants and code decoding for the text console character writer.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS     = 80;
	localparam int ROWS        = 24;
	localparam int TOTAL_CELLS = COLUMNS * ROWS;

	// Field widths
	localparam int ADDR_W = 11;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int CELL_W = 16;
	localparam int CODE_W = 9;
	localparam int ATTR_W = 8;
	localparam int BYTE_W = 8;

	// Attribute after reset
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	// Special codes on the input
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
	localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h0E4;
	localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h0E5;
	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;

	// Bytes on the serial echo
	localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

	// Operation codes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Class of a put code
	typedef enum logic [2:0] {
		KIND_CHAR,
		KIND_NEWLINE,
		KIND_BACKSPACE,
		KIND_LEFT,
		KIND_RIGHT
	} code_kind_t;

	function automatic code_kind_t decode_code(input logic [CODE_W-1:0] code);
		code_kind_t k;
		k = KIND_CHAR;
		if (code == CODE_NEWLINE) begin
			k = KIND_NEWLINE;
		end else if (code == CODE_BACKSPACE) begin
			k = KIND_BACKSPACE;
		end else if (code == CODE_LEFT) begin
			k = KIND_LEFT;
		end else if (code == CODE_RIGHT) begin
			k = KIND_RIGHT;
		end
		return k;
	endfunction

endpackage

[design/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/text_console_character_writer_top.sv]
// Text console character writer: cursor, screen store, scrolling and serial echo.
//
// Input channel (in_valid / in_stall): operation 0 puts char_code at the cursor,
// operation 1 reads the cell at cell_address. A transfer takes place when in_valid
// is high and in_stall low. Output channel (out_valid / out_stall) carries the
// results of a transfer: serial echo byte, cell data on a read, cursor position and
// a last flag. A backspace gives three results, everything else one.
// cfg_write with cfg_data sets the attribute byte of written and blanked cells.
//
// A put or a read is accepted in the idle state, then its result state loads the
// output register. A put that leaves the last row scrolls first: the screen copy
// runs one cell a cycle through the single RAM write port, and a drain state ends it.
// After reset a clearing pass writes zero to all 1920 cells, one a cycle; in_stall
// stays high throughout, the attribute register may be written meanwhile.
// A stalled output holds its result; the next item is still accepted and waits in
// the result state until the output register frees.
module text_console_character_writer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [tcw_pkg::CODE_W-1:0]        char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]        cell_address,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcw_pkg::BYTE_W-1:0]        serial_byte,
	output logic                              serial_valid,
	output logic [tcw_pkg::CELL_W-1:0]        cell_data,
	output logic [tcw_pkg::ADDR_W-1:0]        cursor_pos,
	output logic                              last
);

	localparam int ADDR_W = tcw_pkg::ADDR_W;
	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int CELL_W = tcw_pkg::CELL_W;
	localparam int BYTE_W = tcw_pkg::BYTE_W;
	localparam int ATTR_W = tcw_pkg::ATTR_W;
	localparam int CODE_W = tcw_pkg::CODE_W;

	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(tcw_pkg::TOTAL_CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW0  =
		ADDR_W'(tcw_pkg::TOTAL_CELLS - tcw_pkg::COLUMNS);
	localparam logic [ADDR_W-1:0] COLS_ADDR  = ADDR_W'(tcw_pkg::COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(tcw_pkg::COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(tcw_pkg::ROWS);
	localparam logic [ROW_W-1:0]  BOTTOM_ROW = ROW_W'(tcw_pkg::ROWS - 1);

	// Controller states
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CODE_W-1:0] code_q;
	logic [1:0]        emit_idx_q;
	logic              blank_pend_q;
	logic              rd_ok_q;

	// scroll copy write stage
	logic              wr_vld_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_zero_s1;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] serial_byte_q;
	logic              serial_valid_q;
	logic [CELL_W-1:0] cell_data_q;
	logic [ADDR_W-1:0] cursor_pos_q;
	logic              last_q;

	// RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic                accept;
	logic                out_free;
	logic                out_load;
	tcw_pkg::code_kind_t in_kind;
	tcw_pkg::code_kind_t q_kind;
	logic                copy_phase;

	logic [ADDR_W-1:0] nxt_pos;
	logic [ROW_W-1:0]  nxt_row;
	logic [COL_W-1:0]  nxt_col;
	logic              scroll;

	logic [BYTE_W-1:0] emit_byte;
	logic              emit_bvalid;
	logic              emit_last;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign in_kind    = tcw_pkg::decode_code(char_code);
	assign q_kind     = tcw_pkg::decode_code(code_q);
	assign copy_phase = (cnt_q < LAST_ROW0);

	// Cursor after a put, before any scroll
	always_comb begin
		nxt_pos = pos_q;
		nxt_row = row_q;
		nxt_col = col_q;
		unique case (in_kind)
			tcw_pkg::KIND_NEWLINE: begin
				nxt_pos = pos_q - ADDR_W'(col_q) + COLS_ADDR;
				nxt_row = row_q + ROW_W'(1);
				nxt_col = '0;
			end
			tcw_pkg::KIND_BACKSPACE, tcw_pkg::KIND_LEFT: begin
				if (pos_q != '0) begin
					nxt_pos = pos_q - ADDR_W'(1);
					if (col_q == '0) begin
						nxt_col = LAST_COL;
						nxt_row = row_q - ROW_W'(1);
					end else begin
						nxt_col = col_q - COL_W'(1);
					end
				end
			end
			tcw_pkg::KIND_CHAR, tcw_pkg::KIND_RIGHT: begin
				nxt_pos = pos_q + ADDR_W'(1);
				if (col_q == LAST_COL) begin
					nxt_col = '0;
					nxt_row = row_q + ROW_W'(1);
				end else begin
					nxt_col = col_q + COL_W'(1);
				end
			end
			default: begin
				nxt_pos = pos_q;
			end
		endcase
	end

	assign scroll = (nxt_row == ROW_LIMIT);

	// RAM write port: one writer per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {attr_q, tcw_pkg::BYTE_SPACE};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			ST_SCROLL, ST_DRAIN: begin
				ram_we    = wr_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = wr_zero_s1 ? '0 : ram_rdata;
			end
			ST_EMIT: begin
				ram_we = blank_pend_q;
			end
			ST_IDLE: begin
				ram_we    = accept && (operation == tcw_pkg::OP_PUT) &&
					(in_kind == tcw_pkg::KIND_CHAR);
				ram_wdata = {attr_q, char_code[BYTE_W-1:0]};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// RAM read port: cell read or one row down during scroll
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cell_address;
		if (state_q == ST_SCROLL) begin
			ram_re    = copy_phase;
			ram_raddr = cnt_q + COLS_ADDR;
		end else if (accept && (operation == tcw_pkg::OP_READ)) begin
			ram_re = (cell_address <= LAST_CELL);
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(tcw_pkg::TOTAL_CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Echo byte for the current result
	always_comb begin
		emit_byte   = code_q[BYTE_W-1:0];
		emit_bvalid = 1'b1;
		emit_last   = 1'b1;
		unique case (q_kind)
			tcw_pkg::KIND_BACKSPACE: begin
				emit_byte = (emit_idx_q == 2'd1) ? tcw_pkg::BYTE_SPACE : tcw_pkg::BYTE_BS;
				emit_last = (emit_idx_q == 2'd2);
			end
			tcw_pkg::KIND_LEFT, tcw_pkg::KIND_RIGHT: begin
				emit_byte   = '0;
				emit_bvalid = 1'b0;
			end
			tcw_pkg::KIND_CHAR, tcw_pkg::KIND_NEWLINE: begin
				emit_byte = code_q[BYTE_W-1:0];
			end
			default: begin
				emit_byte = code_q[BYTE_W-1:0];
			end
		endcase
	end

	assign out_load = out_free && ((state_q == ST_EMIT) || (state_q == ST_READ));

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_write) begin
			attr_q <= cfg_data;
		end
	end

	// Controller and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			pos_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			emit_idx_q   <= '0;
			blank_pend_q <= 1'b0;
			wr_vld_s1    <= 1'b0;
		end else begin
			wr_vld_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					emit_idx_q <= '0;
					if (accept) begin
						if (operation == tcw_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else begin
							blank_pend_q <= (in_kind != tcw_pkg::KIND_LEFT) &&
								(in_kind != tcw_pkg::KIND_RIGHT);
							cnt_q <= '0;
							if (scroll) begin
								pos_q   <= LAST_ROW0;
								row_q   <= BOTTOM_ROW;
								col_q   <= '0;
								state_q <= ST_SCROLL;
							end else begin
								pos_q   <= nxt_pos;
								row_q   <= nxt_row;
								col_q   <= nxt_col;
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_SCROLL: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					blank_pend_q <= 1'b0;
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 2'd1;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload of the accepted item and of the scroll write stage
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q  <= char_code;
			rd_ok_q <= (cell_address <= LAST_CELL);
		end
		wr_addr_s1 <= cnt_q;
		wr_zero_s1 <= !copy_phase;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			cursor_pos_q <= pos_q;
			if (state_q == ST_READ) begin
				serial_byte_q  <= '0;
				serial_valid_q <= 1'b0;
				cell_data_q    <= rd_ok_q ? ram_rdata : '0;
				last_q         <= 1'b1;
			end else begin
				serial_byte_q  <= emit_byte;
				serial_valid_q <= emit_bvalid;
				cell_data_q    <= '0;
				last_q         <= emit_last;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign serial_byte  = serial_byte_q;
	assign serial_valid = serial_valid_q;
	assign cell_data    = cell_data_q;
	assign cursor_pos   = cursor_pos_q;
	assign last         = last_q;

endmodule
